// ===== hw/rtl/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants, codes and control types of the bounded LIFO stack.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int ACT_W      = 2;
  localparam int ST_W       = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // capture the accepted operation and access the memory
    logic emit;  // load the result register
  } bls_cmd_t;

endpackage

// ===== hw/rtl/bls_ctrl.sv =====
// ----------------------------------------------------------------------------
// bls_ctrl
// Controller: sequences one operation through memory access and result load.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bls_pkg::bls_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.take      = in_valid && (state_r == S_IDLE);
    cmd.emit      = (state_r == S_EXEC) && slot_free;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.take) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/bls_dpath.sv =====
// ----------------------------------------------------------------------------
// bls_dpath
// Datapath: capacity register, entry count, stack memory and result register.
// ----------------------------------------------------------------------------
module bls_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bls_pkg::bls_cmd_t                   cmd,
  input  logic                                cfg_write,
  input  logic        [bls_pkg::CNT_W-1:0]      cfg_data,
  input  logic        [bls_pkg::ACT_W-1:0]      in_action,
  input  logic signed [bls_pkg::DATA_WIDTH-1:0] in_push_value,
  input  logic        [bls_pkg::CNT_W-1:0]      in_peek_position,
  output logic signed [bls_pkg::DATA_WIDTH-1:0] out_value,
  output logic        [bls_pkg::ST_W-1:0]       out_status,
  output logic        [bls_pkg::CNT_W-1:0]      out_count,
  output logic                                out_full_res,
  output logic                                out_empty_res
);

  logic [bls_pkg::DATA_WIDTH-1:0] mem [bls_pkg::DEPTH];

  logic [bls_pkg::CNT_W-1:0]      cap_r, eff_cap;
  logic [bls_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [bls_pkg::ST_W-1:0]       st_nxt, st_r;
  logic                           rd_nxt, rd_r;
  logic [bls_pkg::CNT_W-1:0]      addr_full;
  logic [bls_pkg::ADDR_W-1:0]     addr;
  logic                           wr_en;
  logic [bls_pkg::DATA_WIDTH-1:0] rdata_r;

  logic signed [bls_pkg::DATA_WIDTH-1:0] value_r;
  logic        [bls_pkg::ST_W-1:0]       status_r;
  logic        [bls_pkg::CNT_W-1:0]      ocount_r;
  logic                                  full_r, empty_r;

  assign eff_cap = (cap_r > bls_pkg::DEPTH_CNT) ? bls_pkg::DEPTH_CNT : cap_r;

  // Decide the outcome of the operation at the accept edge.
  always_comb begin
    count_nxt = count_r;
    st_nxt    = bls_pkg::ST_OK;
    rd_nxt    = 1'b0;
    wr_en     = 1'b0;
    addr_full = count_r;
    unique case (in_action)
      bls_pkg::ACT_PUSH: begin
        if (count_r >= eff_cap) begin
          st_nxt = bls_pkg::ST_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      bls_pkg::ACT_POP: begin
        addr_full = count_r - 1'b1;
        if (count_r == '0) begin
          st_nxt = bls_pkg::ST_UNDERFLOW;
        end else begin
          rd_nxt    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      bls_pkg::ACT_PEEK: begin
        addr_full = count_r - in_peek_position;
        if (in_peek_position == '0 || in_peek_position > count_r) begin
          st_nxt = bls_pkg::ST_BADPOS;
        end else begin
          rd_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign addr = addr_full[bls_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) mem[addr] <= in_push_value;
    if (cmd.take && rd_nxt) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= bls_pkg::CAP_RESET;
      count_r <= '0;
    end else begin
      if (cfg_write) cap_r <= cfg_data;
      if (cmd.take) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      st_r <= st_nxt;
      rd_r <= rd_nxt;
    end
    if (cmd.emit) begin
      value_r  <= rd_r ? rdata_r : '0;
      status_r <= st_r;
      ocount_r <= count_r;
      full_r   <= (count_r >= eff_cap);
      empty_r  <= (count_r == '0);
    end
  end

  assign out_value     = value_r;
  assign out_status    = status_r;
  assign out_count     = ocount_r;
  assign out_full_res  = full_r;
  assign out_empty_res = empty_r;

endmodule

// ===== hw/rtl/bounded_lifo_stack.sv =====
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack with a programmable capacity: push, pop and peek.
// ----------------------------------------------------------------------------
// A result is presented when the result register is loaded; the registered
// read port of the stack memory lies between acceptance and that load, and no
// new operation is taken until the current one has loaded its result.
// A result waiting in the output register does not block the next transfer in.
// Reset (synchronous, rst_n low): entry count 0, capacity 64, no result pending.
// The stack memory is not cleared; only entries pushed since reset are read.
module bounded_lifo_stack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [bls_pkg::CNT_W-1:0]      cfg_capacity,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [bls_pkg::ACT_W-1:0]      in_action,
  input  logic signed [bls_pkg::DATA_WIDTH-1:0] in_push_value,
  input  logic        [bls_pkg::CNT_W-1:0]      in_peek_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bls_pkg::DATA_WIDTH-1:0] out_value,
  output logic        [bls_pkg::ST_W-1:0]       out_status,
  output logic        [bls_pkg::CNT_W-1:0]      out_count,
  output logic                                out_full_res,
  output logic                                out_empty_res
);

  bls_pkg::bls_cmd_t cmd;

  // The capacity register takes a write on every cycle; software writes it
  // only while the stack is idle.
  assign cfg_ready = 1'b1;

  // The controller accepts an operation when idle, then loads the registered
  // memory read into the result register once the output slot is free.
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the count, the capacity, the memory and the result.
  bls_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_capacity),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .in_peek_position (in_peek_position),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_full_res     (out_full_res),
    .out_empty_res    (out_empty_res)
  );

  // After a transfer in, the block is busy while the memory access is in flight.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  // Overflow is reported only when the stack is at its capacity.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bls_pkg::ST_OVERFLOW |-> out_full_res)
    else $error("overflow reported while the stack is not full");

  // Underflow is reported only on an empty stack, with a zero value.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bls_pkg::ST_UNDERFLOW |-> out_empty_res && out_value == '0)
    else $error("underflow reported on a non-empty stack");

endmodule

// ===== tb/bounded_lifo_stack_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack_tb
// Self-checking bench for the bounded LIFO stack. Push, pop, peek and no-op
// operations are queued by phase and fed to the block through a driver. A
// mirror of the stack predicts every result, and a monitor compares each
// returned result with the oldest prediction. The capacity is rewritten
// between phases, including zero and values above the memory depth.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_tb;
  import bls_pkg::*;

  // The action field is two bits wide, so code three reaches the block too.
  // The block treats it as a no-op that still returns a result.
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  // A stall this long fills the result path and backs up the input side.
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int IDLE_PCT         = 22;

  typedef struct {
    logic        [ACT_W-1:0]      act;
    logic signed [DATA_WIDTH-1:0] val;
    logic        [CNT_W-1:0]      pos;
  } stack_op_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] value;
    logic        [ST_W-1:0]       status;
    logic        [CNT_W-1:0]      count;
    logic                         full;
    logic                         empty;
  } stack_answer_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic        [CNT_W-1:0]      cfg_capacity = CAP_RESET;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic        [ACT_W-1:0]      in_action = ACT_PUSH;
  logic signed [DATA_WIDTH-1:0] in_push_value = '0;
  logic        [CNT_W-1:0]      in_peek_position = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic        [ST_W-1:0]       out_status;
  logic        [CNT_W-1:0]      out_count;
  logic                         out_full_res;
  logic                         out_empty_res;

  bounded_lifo_stack DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_capacity     (cfg_capacity),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .in_peek_position (in_peek_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_full_res     (out_full_res),
    .out_empty_res    (out_empty_res)
  );

  // Free-running 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Operations waiting to be offered, and results still owed by the block.
  stack_op_t     op_queue[$];
  stack_answer_t stack_answers[$];

  // Mirror of the stack as the block should hold it. Only entries below the
  // count are ever read, and each of those was pushed since reset.
  logic signed [DATA_WIDTH-1:0] mirror_mem [DEPTH];
  int                           mirror_count = 0;
  int                           mirror_cap   = CAP_RESET;

  // Generation-side view of the count. Operations are accepted in the order
  // they are queued and the capacity only changes between phases, so this
  // tracks exactly what the stack will hold when each operation arrives.
  int gen_count = 0;
  int gen_cap   = DEPTH;

  int ops_queued = 0;
  int ops_sent   = 0;
  int mismatches = 0;

  // Both sides run without gaps while this many transfers have gone in.
  function automatic logic calm_window();
    return ops_sent >= 900 && ops_sent < 1200;
  endfunction

  // Applies one operation to the mirror and returns the result it must give.
  function automatic stack_answer_t apply_stack_op(stack_op_t op);
    stack_answer_t ans;
    int            cap_eff;
    cap_eff    = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
    ans.value  = '0;
    ans.status = ST_OK;
    case (op.act)
      ACT_PUSH: begin
        if (mirror_count >= cap_eff) begin
          ans.status = ST_OVERFLOW;
        end else begin
          mirror_mem[mirror_count] = op.val;
          mirror_count++;
        end
      end
      ACT_POP: begin
        if (mirror_count == 0) begin
          ans.status = ST_UNDERFLOW;
        end else begin
          mirror_count--;
          ans.value = mirror_mem[mirror_count];
        end
      end
      ACT_PEEK: begin
        // Position one is the top; zero or anything past the count is bad,
        // which also covers every position on an empty stack.
        if (op.pos == 0 || int'(op.pos) > mirror_count) begin
          ans.status = ST_BADPOS;
        end else begin
          ans.value = mirror_mem[mirror_count - int'(op.pos)];
        end
      end
      default: begin
        // The no-op code leaves everything alone and reports the state.
      end
    endcase
    ans.count = CNT_W'(mirror_count);
    ans.full  = (mirror_count >= cap_eff);
    ans.empty = (mirror_count == 0);
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 20) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Queues one operation and keeps the generation-side count in step.
  task automatic queue_op(input logic [ACT_W-1:0] act,
                          input logic signed [DATA_WIDTH-1:0] val,
                          input logic [CNT_W-1:0] pos);
    stack_op_t op;
    op.act = act;
    op.val = val;
    op.pos = pos;
    if (act == ACT_PUSH && gen_count < gen_cap) begin
      gen_count++;
    end else if (act == ACT_POP && gen_count > 0) begin
      gen_count--;
    end
    op_queue.push_back(op);
    ops_queued++;
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Most peeks land on a live entry; the rest sweep the whole field,
  // position zero and positions past the count among them.
  function automatic logic [CNT_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 80) begin
      return CNT_W'($urandom_range(1, (gen_count > 0) ? gen_count : 1));
    end
    return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
  endfunction

  // Random operations as a biased walk: bursts that mostly fill, mostly
  // drain, or mix, so the stack runs repeatedly between empty and full.
  task automatic queue_random_ops(input int n);
    int mode;
    int roll;
    int push_pct;
    int pop_pct;
    mode = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        mode = $urandom_range(0, 2);
      end
      push_pct = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
      pop_pct  = (mode == 0) ? 20 : (mode == 1) ? 65 : 40;
      roll     = $urandom_range(0, 99);
      if (roll < push_pct) begin
        queue_op(ACT_PUSH, pick_word(), CNT_W'($urandom));
      end else if (roll < push_pct + pop_pct) begin
        queue_op(ACT_POP, $urandom, CNT_W'($urandom));
      end else if (roll < 98) begin
        queue_op(ACT_PEEK, $urandom, pick_position());
      end else begin
        queue_op(ACT_NOP, $urandom, CNT_W'($urandom));
      end
    end
  endtask

  // Waits, sampling away from the active edge, until every queued operation
  // has gone in and every result has come back.
  task automatic wait_drained();
    do @(negedge clk); while (ops_sent != ops_queued || stack_answers.size() != 0);
  endtask

  // The capacity is only rewritten with nothing in flight. The short pause
  // follows the return of the last result.
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_capacity <= cap;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    mirror_cap = cap;
    gen_cap    = (int'(cap) > DEPTH) ? DEPTH : int'(cap);
  endtask

  // Driver: predicts the result of each accepted transfer, then offers the
  // next operation whenever the input slot is free and no gap is rolled.
  always @(posedge clk) begin
    stack_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        op.act = in_action;
        op.val = in_push_value;
        op.pos = in_peek_position;
        stack_answers.push_back(apply_stack_op(op));
        ops_sent++;
      end
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 &&
            (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          op = op_queue.pop_front();
          in_action        <= op.act;
          in_push_value    <= op.val;
          in_peek_position <= op.pos;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold once a few hundred
  // transfers have gone in, which fills the block and stalls its input.
  int  hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && ops_sent >= 400) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_window() || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor: every accepted result is checked field by field against the
  // oldest outstanding prediction.
  always @(posedge clk) begin
    stack_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (stack_answers.size() == 0) begin
        report_mismatch("unexpected result", out_value, '0);
      end else begin
        want = stack_answers.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_count !== want.count) report_mismatch("count", out_count, want.count);
        if (out_full_res !== want.full) report_mismatch("full", out_full_res, want.full);
        if (out_empty_res !== want.empty) begin
          report_mismatch("empty", out_empty_res, want.empty);
        end
      end
    end
  end

  // Stimulus sequence. Each phase runs under one capacity setting.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks at the reset capacity: an empty stack underflows, rejects
    // every peek and reports its state on a no-op; the extreme words go in and
    // come back from every depth; bad peek positions on both sides of the count.
    queue_op(ACT_POP,  '0, '0);
    queue_op(ACT_PEEK, '0, CNT_W'(1));
    queue_op(ACT_NOP,  '0, '0);
    queue_op(ACT_PUSH, 32'sh7FFF_FFFF, '0);
    queue_op(ACT_PUSH, 32'sh8000_0000, '0);
    queue_op(ACT_PUSH, -32'sd1, '0);
    queue_op(ACT_PUSH, '0, CNT_W'(127));
    queue_op(ACT_PEEK, '0, CNT_W'(1));
    queue_op(ACT_PEEK, '0, CNT_W'(4));
    queue_op(ACT_PEEK, '0, CNT_W'(5));
    queue_op(ACT_PEEK, '0, '0);
    queue_op(ACT_PEEK, -32'sd1, CNT_W'(127));
    queue_op(ACT_NOP,  -32'sd1, CNT_W'(127));
    repeat (4) queue_op(ACT_POP, '0, '0);
    queue_op(ACT_POP,  '0, '0);
    queue_op(ACT_PEEK, '0, CNT_W'(64));

    // Zero capacity: every push overflows and the empty stack is also full.
    write_capacity('0);
    queue_op(ACT_PUSH, 32'sh1234_5678, '0);
    queue_op(ACT_POP,  '0, '0);
    queue_op(ACT_PEEK, '0, CNT_W'(1));
    queue_op(ACT_NOP,  '0, '0);

    write_capacity(CNT_W'(1));
    queue_random_ops(200);

    // Capacity above the depth saturates. Fill to the top, try one more push,
    // and peek at the deepest position and just past it.
    write_capacity(CNT_W'(127));
    queue_random_ops(150);
    while (gen_count < DEPTH) queue_op(ACT_PUSH, pick_word(), '0);
    queue_op(ACT_PUSH, pick_word(), '0);
    queue_op(ACT_PEEK, '0, CNT_W'(DEPTH));
    queue_op(ACT_PEEK, '0, CNT_W'(DEPTH + 1));
    queue_op(ACT_PEEK, '0, CNT_W'(1));

    // Lowering the capacity under a full stack keeps the entries: pushes
    // overflow, pops still work and the full flag holds until below capacity.
    write_capacity(CNT_W'(3));
    queue_random_ops(150);

    write_capacity(CNT_W'(64));
    queue_random_ops(300);

    write_capacity(CNT_W'(2));
    queue_random_ops(200);

    write_capacity(CNT_W'(100));
    queue_random_ops(300);

    write_capacity(CNT_W'(17));
    queue_random_ops(250);

    write_capacity(CNT_W'(64));
    queue_random_ops(250);

    // Let everything come back, then allow a few cycles for stray output.
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && stack_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
